[hw/rtl/mtm_pkg.sv]
// Shared constants and types for the masked template matcher.
package mtm_pkg;

    localparam int TEMPLATE_MAX_DEF = 16;
    localparam int CHARS_STORED     = 16;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_ADDR_W       = 5;
    localparam int LEN_W            = 5;
    localparam int FIELD_W          = 4;

    typedef enum logic [1:0] {
        CODE_MATCH     = 2'd0,
        CODE_ONE       = 2'd1,
        CODE_UNTIL     = 2'd2,
        CODE_MATCH_ALT = 2'd3
    } t_code;

    typedef enum logic [1:0] {
        REG_TMPL_LO  = 2'd0,
        REG_TMPL_HI  = 2'd1,
        REG_CODES    = 2'd2,
        REG_LENGTH   = 2'd3
    } t_reg;

endpackage

[hw/rtl/masked_template_matcher.sv]
// Masked template matcher: one received byte per word in, one result word out.
//
// Each accepted rx byte gives exactly one result word. The block takes one byte per
// cycle without gaps while results are taken; a result held by i_res_ready low stalls
// the input once the input register is full. A byte passes the input register, then
// the result register, before its result is on the outputs, and a byte may be accepted
// while a finished result still waits to be taken. The rate is set by the template
// position/field state update. Configuration uses an APB-style port with 64-bit data:
// template_low at 0x00, template_high at 0x08, position_codes at 0x10 and template_length
// at 0x18; only paddr[4:3] selects the register. Write it only while the block is idle.
module masked_template_matcher #(
    parameter int TEMPLATE_MAX = mtm_pkg::TEMPLATE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mtm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mtm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    // input words
    input  logic                          i_rx_valid,
    output logic                          o_rx_ready,
    input  logic [7:0]                    i_rx_byte,
    // result words
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [7:0]                    o_data_byte,
    output logic                          o_capture_valid,
    output logic [mtm_pkg::FIELD_W-1:0]   o_field_index,
    output logic                          o_field_start,
    output logic                          o_frame_done,
    output logic                          o_mismatch
);
    import mtm_pkg::*;

    // position runs up to length + 1 after a terminator skip
    localparam int PW = $clog2(TEMPLATE_MAX + 2);
    localparam int XW = 6;

    // configuration
    logic [63:0]      r_tmpl_lo;
    logic [63:0]      r_tmpl_hi;
    logic [31:0]      r_codes;
    logic [LEN_W-1:0] r_len;
    logic             cfg_wr;
    t_reg             cfg_sel;

    // frame state
    logic [PW-1:0]      r_pos, n_pos;
    t_code              r_prev, n_prev;
    logic [FIELD_W-1:0] r_fc, n_fc;
    logic               r_open, n_open;

    // pipeline
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    logic [7:0]         r_data, n_data;
    logic               r_cap, n_cap;
    logic [FIELD_W-1:0] r_idx, n_idx;
    logic               r_start, n_start;
    logic               r_done, n_done;
    logic               r_miss, n_miss;
    logic               proc_fire;

    // datapath
    logic [XW-1:0]  len_x;
    logic [PW-1:0]  len_eff;
    logic           restart;
    logic [PW-1:0]  pos_eff;
    logic [XW-1:0]  pos_x;
    logic           in_range;
    logic [3:0]     idx;
    logic [135:0]   tmpl_pad;
    logic [15:0]    window;
    logic [7:0]     ch_cur;
    logic [7:0]     ch_look;
    t_code          code_raw;
    t_code          code;
    t_code          prev_base;
    logic [FIELD_W-1:0] fc_base;
    logic           open_base;
    logic           look_ok;
    logic [PW-1:0]  pos_adv;

    assign pready  = 1'b1;
    assign cfg_sel = t_reg'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_sel)
            REG_TMPL_LO: prdata = r_tmpl_lo;
            REG_TMPL_HI: prdata = r_tmpl_hi;
            REG_CODES:   prdata = {32'd0, r_codes};
            REG_LENGTH:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, r_len};
            default:     prdata = '0;
        endcase
    end

    assign proc_fire  = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || proc_fire;

    // effective length: zero acts as one, clamp to the template maximum
    always_comb begin
        len_x = {{(XW-LEN_W){1'b0}}, r_len};
        if (len_x == '0) begin
            len_x = XW'(1);
        end
        if (len_x > XW'(TEMPLATE_MAX)) begin
            len_x = XW'(TEMPLATE_MAX);
        end
        len_eff = PW'(len_x);
    end

    // stale position after a length change restarts the frame
    assign restart   = (r_pos >= len_eff);
    assign pos_eff   = restart ? '0 : r_pos;
    assign prev_base = restart ? CODE_MATCH : r_prev;
    assign fc_base   = restart ? '0 : r_fc;
    assign open_base = restart ? 1'b0 : r_open;

    assign pos_x    = XW'(pos_eff);
    assign in_range = (pos_x < XW'(CHARS_STORED));
    assign idx      = pos_x[3:0];
    assign tmpl_pad = {8'd0, r_tmpl_hi, r_tmpl_lo};
    // current and next character in one read; beyond the stored characters both read 0
    assign window   = in_range ? tmpl_pad[{idx, 3'b000} +: 16] : 16'd0;
    assign ch_cur   = window[7:0];
    assign look_ok  = ((pos_x + XW'(1)) < XW'(len_eff));
    assign ch_look  = look_ok ? window[15:8] : 8'd0;
    assign code_raw = in_range ? t_code'(r_codes[{idx, 1'b0} +: 2]) : CODE_MATCH;
    assign code     = (code_raw == CODE_MATCH_ALT) ? CODE_MATCH : code_raw;

    always_comb begin
        n_pos   = pos_eff;
        n_prev  = prev_base;
        n_fc    = fc_base;
        n_open  = open_base;
        n_data  = 8'd0;
        n_cap   = 1'b0;
        n_idx   = '0;
        n_start = 1'b0;
        n_done  = 1'b0;
        n_miss  = 1'b0;
        pos_adv = pos_eff;
        if (code == CODE_ONE || (code == CODE_UNTIL && r_in_byte != ch_look)) begin
            if (prev_base == CODE_MATCH) begin
                if (open_base) begin
                    n_fc = fc_base + FIELD_W'(1);
                end
                n_open  = 1'b1;
                n_start = 1'b1;
            end
            n_data = r_in_byte;
            n_cap  = 1'b1;
            n_idx  = n_fc;
            n_prev = code;
            if (code == CODE_ONE) begin
                pos_adv = pos_eff + PW'(1);
            end
        end else if (code == CODE_UNTIL) begin
            // terminator byte: skip it along with the capture position
            pos_adv = pos_eff + PW'(2);
            n_prev  = CODE_MATCH;
        end else if (r_in_byte == ch_cur) begin
            pos_adv = pos_eff + PW'(1);
            n_prev  = CODE_MATCH;
        end else begin
            n_miss = 1'b1;
        end
        n_pos = pos_adv;
        if (!n_miss && pos_adv >= len_eff) begin
            n_done = 1'b1;
        end
        if (n_miss || n_done) begin
            n_pos  = '0;
            n_prev = CODE_MATCH;
            n_fc   = '0;
            n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmpl_lo   <= '0;
            r_tmpl_hi   <= '0;
            r_codes     <= '0;
            r_len       <= LEN_W'(1);
            r_pos       <= '0;
            r_prev      <= CODE_MATCH;
            r_fc        <= '0;
            r_open      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_sel)
                    REG_TMPL_LO: r_tmpl_lo <= pwdata;
                    REG_TMPL_HI: r_tmpl_hi <= pwdata;
                    REG_CODES:   r_codes   <= pwdata[31:0];
                    REG_LENGTH:  r_len     <= pwdata[LEN_W-1:0];
                    default:     ;
                endcase
            end
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (proc_fire) begin
                r_pos       <= n_pos;
                r_prev      <= n_prev;
                r_fc        <= n_fc;
                r_open      <= n_open;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (proc_fire) begin
            r_data  <= n_data;
            r_cap   <= n_cap;
            r_idx   <= n_idx;
            r_start <= n_start;
            r_done  <= n_done;
            r_miss  <= n_miss;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_data_byte     = r_data;
    assign o_capture_valid = r_cap;
    assign o_field_index   = r_idx;
    assign o_field_start   = r_start;
    assign o_frame_done    = r_done;
    assign o_mismatch      = r_miss;

    a_done_not_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_frame_done && o_mismatch))
        else $error("frame done and mismatch in one word");

    a_miss_no_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_mismatch |-> !o_capture_valid && o_data_byte == 8'd0)
        else $error("mismatch word carries a capture");

    a_start_is_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_field_start |-> o_capture_valid)
        else $error("field start without capture");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> $stable(r_pos) && $stable(r_fc) && o_res_valid)
        else $error("frame state moved while result stalled");

endmodule
